FILE: rtl/core/irt_pkg.sv
// Package for the integer-to-radix-text unit: shared types, codes and helper functions.
// Has no dependencies; every other file of the unit refers to it by scoped names.

package irt_pkg;

    // Widths of the transaction fields and internal counters.
    localparam int unsigned NUM_W      = 32;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned RADIX_W    = 5;
    localparam int unsigned SYMS_W     = 64;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned MAX_SYMBOLS = 16;
    localparam int unsigned MAX_DIGITS  = 32;
    localparam int unsigned DIG_IDX_W  = $clog2(MAX_DIGITS);
    localparam int unsigned DIG_CNT_W  = DIG_IDX_W + 1;
    localparam int unsigned BITS_PER_STEP = 8;
    localparam int unsigned STEPS_PER_DIGIT = NUM_W / BITS_PER_STEP;
    localparam int unsigned STEP_W     = $clog2(STEPS_PER_DIGIT);

    // Configuration bus geometry: 64-bit registers at 8-byte spacing.
    localparam int unsigned PDATA_W    = 64;
    localparam int unsigned PADDR_W    = 5;

    // Register indexes.
    localparam logic [1:0] REG_RADIX   = 2'd0;
    localparam logic [1:0] REG_SYM_LO  = 2'd1;
    localparam logic [1:0] REG_SYM_HI  = 2'd2;

    // Reset values: radix ten with the digits '0' to '7' in the low symbol word.
    localparam logic [RADIX_W-1:0] RADIX_RESET  = 5'd10;
    localparam logic [SYMS_W-1:0]  SYM_LO_RESET = 64'h3736_3534_3332_3130;
    localparam logic [SYMS_W-1:0]  SYM_HI_RESET = 64'h0;

    // Special characters.
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
    localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_EMIT   = 3'b100
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic divide;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic digit_final;
        logic emit_final;
        logic out_free;
    } t_dp_status;

    // Pick alphabet symbol idx out of the two symbol words.
    function automatic logic [CHAR_W-1:0] symbol_at(
        input logic [SYMS_W-1:0]  sym_lo,
        input logic [SYMS_W-1:0]  sym_hi,
        input logic [DIGIT_W-1:0] idx
    );
        logic [CHAR_W-1:0] s;
        if (idx[DIGIT_W-1]) begin
            s = sym_hi[{idx[DIGIT_W-2:0], 3'b000} +: CHAR_W];
        end else begin
            s = sym_lo[{idx[DIGIT_W-2:0], 3'b000} +: CHAR_W];
        end
        return s;
    endfunction

    // The alphabet is usable when the radix is in range and the symbols in use
    // are neither sign characters nor repeats of an earlier symbol.
    function automatic logic alphabet_ok(
        input logic [RADIX_W-1:0] radix,
        input logic [SYMS_W-1:0]  sym_lo,
        input logic [SYMS_W-1:0]  sym_hi
    );
        logic              ok;
        logic [CHAR_W-1:0] si;
        ok = (radix >= RADIX_W'(2)) && (radix <= RADIX_W'(MAX_SYMBOLS));
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            si = symbol_at(sym_lo, sym_hi, DIGIT_W'(i));
            if (RADIX_W'(i) < radix) begin
                if ((si == PLUS_CHAR) || (si == MINUS_CHAR)) begin
                    ok = 1'b0;
                end
                for (int j = 0; j < i; j++) begin
                    if (symbol_at(sym_lo, sym_hi, DIGIT_W'(j)) == si) begin
                        ok = 1'b0;
                    end
                end
            end
        end
        return ok;
    endfunction

endpackage

FILE: rtl/core/irt_ifs.sv
// Handshake interfaces for the number input and the character output channels.
// Depends on irt_pkg for field widths.

interface irt_num_if;
    logic                             valid;
    logic                             ready;
    logic signed [irt_pkg::NUM_W-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface irt_chr_if;
    logic                       valid;
    logic                       ready;
    logic [irt_pkg::CHAR_W-1:0] character;
    logic                       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

FILE: rtl/core/irt_cfg_regs.sv
// Configuration registers of the radix text unit behind an APB-style port.
// Also derives the alphabet check. Depends on irt_pkg.

module irt_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [irt_pkg::PADDR_W-1:0] paddr,
    input  logic [irt_pkg::PDATA_W-1:0] pwdata,
    output logic [irt_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic [irt_pkg::RADIX_W-1:0] o_radix,
    output logic [irt_pkg::SYMS_W-1:0]  o_sym_lo,
    output logic [irt_pkg::SYMS_W-1:0]  o_sym_hi,
    output logic                        o_alpha_ok
);

    logic [irt_pkg::RADIX_W-1:0] r_radix;
    logic [irt_pkg::SYMS_W-1:0]  r_sym_lo;
    logic [irt_pkg::SYMS_W-1:0]  r_sym_hi;
    logic [1:0]                  w_index;
    logic                        w_write;

    assign pready  = 1'b1;
    assign w_index = paddr[irt_pkg::PADDR_W-1:3];
    assign w_write = psel && penable && pwrite && pready;

    // Register writes in the access phase; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= irt_pkg::RADIX_RESET;
            r_sym_lo <= irt_pkg::SYM_LO_RESET;
            r_sym_hi <= irt_pkg::SYM_HI_RESET;
        end else if (w_write) begin
            case (w_index)
                irt_pkg::REG_RADIX:  r_radix  <= pwdata[irt_pkg::RADIX_W-1:0];
                irt_pkg::REG_SYM_LO: r_sym_lo <= pwdata;
                irt_pkg::REG_SYM_HI: r_sym_hi <= pwdata;
                default: ;
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        case (w_index)
            irt_pkg::REG_RADIX:  prdata = irt_pkg::PDATA_W'(r_radix);
            irt_pkg::REG_SYM_LO: prdata = r_sym_lo;
            irt_pkg::REG_SYM_HI: prdata = r_sym_hi;
            default:             prdata = '0;
        endcase
    end

    assign o_radix    = r_radix;
    assign o_sym_lo   = r_sym_lo;
    assign o_sym_hi   = r_sym_hi;
    assign o_alpha_ok = irt_pkg::alphabet_ok(r_radix, r_sym_lo, r_sym_hi);

endmodule

FILE: rtl/core/irt_ctrl.sv
// Controller state machine of the radix text unit: accept, divide, emit.
// Depends on irt_pkg for the state type and the command and status structs.

module irt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_alpha_ok,
    input  irt_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output irt_pkg::t_dp_cmd    o_cmd
);

    irt_pkg::t_state r_state;
    irt_pkg::t_state n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            irt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                // A transaction with an unusable alphabet is taken and dropped.
                if (i_in_valid && i_alpha_ok) begin
                    o_cmd.load = 1'b1;
                    n_state    = irt_pkg::ST_DIVIDE;
                end
            end
            irt_pkg::ST_DIVIDE: begin
                o_cmd.divide = 1'b1;
                if (i_status.digit_final) begin
                    n_state = irt_pkg::ST_EMIT;
                end
            end
            irt_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_final) begin
                        n_state = irt_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = irt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= irt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A loaded number always moves on to division.
    a_load_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == irt_pkg::ST_DIVIDE))
        else $error("load did not start division");

endmodule

FILE: rtl/core/irt_datapath.sv
// Datapath of the radix text unit: magnitude, shared restoring divider,
// digit store and the output register. Depends on irt_pkg.

module irt_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  irt_pkg::t_dp_cmd                 i_cmd,
    input  logic signed [irt_pkg::NUM_W-1:0] i_number,
    input  logic [irt_pkg::RADIX_W-1:0]      i_radix,
    input  logic [irt_pkg::SYMS_W-1:0]       i_sym_lo,
    input  logic [irt_pkg::SYMS_W-1:0]       i_sym_hi,
    input  logic                             i_out_ready,
    output irt_pkg::t_dp_status              o_status,
    output logic                             o_out_valid,
    output logic [irt_pkg::CHAR_W-1:0]       o_character,
    output logic                             o_last
);

    logic [irt_pkg::NUM_W-1:0]     r_work;
    logic [irt_pkg::DIGIT_W-1:0]   r_rem;
    logic [irt_pkg::STEP_W-1:0]    r_step;
    logic [irt_pkg::DIG_CNT_W-1:0] r_count;
    logic                          r_sign_pend;
    logic [irt_pkg::DIGIT_W-1:0]   r_digits [irt_pkg::MAX_DIGITS];
    logic [irt_pkg::DIGIT_W-1:0]   r_dig_rd;
    logic                          r_ovalid;
    logic [irt_pkg::CHAR_W-1:0]    r_ochar;
    logic                          r_olast;

    logic [irt_pkg::NUM_W-1:0]     w_mag;
    logic [irt_pkg::NUM_W-1:0]     n_work;
    logic [irt_pkg::RADIX_W-1:0]   n_rem;
    logic                          w_step_end;
    logic [irt_pkg::DIG_CNT_W-1:0] w_cnt_dec;
    logic [irt_pkg::DIG_CNT_W-1:0] w_cnt_dec2;
    logic [irt_pkg::DIG_IDX_W-1:0] w_rd_addr;
    logic [irt_pkg::CHAR_W-1:0]    w_char;
    logic                          w_last;

    // Magnitude as unsigned, so the most negative number converts correctly.
    assign w_mag = i_number[irt_pkg::NUM_W-1] ? (irt_pkg::NUM_W'(0) - i_number)
                                              : i_number;

    // Eight quotient bits per cycle; the dividend shifts out at the top and
    // the quotient shifts in at the bottom.
    always_comb begin
        logic [irt_pkg::RADIX_W-1:0] trial;
        n_work = r_work;
        n_rem  = irt_pkg::RADIX_W'(r_rem);
        for (int k = 0; k < irt_pkg::BITS_PER_STEP; k++) begin
            trial  = {n_rem[irt_pkg::DIGIT_W-1:0], n_work[irt_pkg::NUM_W-1]};
            n_work = {n_work[irt_pkg::NUM_W-2:0], 1'b0};
            if (trial >= i_radix) begin
                n_rem     = trial - i_radix;
                n_work[0] = 1'b1;
            end else begin
                n_rem = trial;
            end
        end
    end

    assign w_step_end = (r_step == irt_pkg::STEP_W'(irt_pkg::STEPS_PER_DIGIT - 1));

    // Division state and digit count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work      <= '0;
            r_rem       <= '0;
            r_step      <= '0;
            r_count     <= '0;
            r_sign_pend <= 1'b0;
        end else if (i_cmd.load) begin
            r_work      <= w_mag;
            r_rem       <= '0;
            r_step      <= '0;
            r_count     <= '0;
            r_sign_pend <= i_number[irt_pkg::NUM_W-1];
        end else if (i_cmd.divide) begin
            r_work <= n_work;
            r_step <= r_step + irt_pkg::STEP_W'(1);
            if (w_step_end) begin
                r_rem   <= '0;
                r_count <= r_count + irt_pkg::DIG_CNT_W'(1);
            end else begin
                r_rem <= n_rem[irt_pkg::DIGIT_W-1:0];
            end
        end else if (i_cmd.emit) begin
            if (r_sign_pend) begin
                r_sign_pend <= 1'b0;
            end else begin
                r_count <= w_cnt_dec;
            end
        end
    end

    // Digit store, least significant digit at entry zero. The read register
    // always holds the digit that the next character needs; a digit written
    // in this cycle is passed straight through to it.
    assign w_cnt_dec2 = r_count - irt_pkg::DIG_CNT_W'(2);
    assign w_rd_addr  = (i_cmd.emit && !r_sign_pend) ? w_cnt_dec2[irt_pkg::DIG_IDX_W-1:0]
                                                     : w_cnt_dec[irt_pkg::DIG_IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.divide && w_step_end) begin
            r_digits[r_count[irt_pkg::DIG_IDX_W-1:0]] <= n_rem[irt_pkg::DIGIT_W-1:0];
            r_dig_rd <= n_rem[irt_pkg::DIGIT_W-1:0];
        end else begin
            r_dig_rd <= r_digits[w_rd_addr];
        end
    end

    // Next character: the sign first, then the digits from the top down.
    assign w_cnt_dec = r_count - irt_pkg::DIG_CNT_W'(1);
    assign w_char = r_sign_pend ? irt_pkg::MINUS_CHAR
                  : irt_pkg::symbol_at(i_sym_lo, i_sym_hi, r_dig_rd);
    assign w_last = !r_sign_pend && (r_count == irt_pkg::DIG_CNT_W'(1));

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ochar <= w_char;
            r_olast <= w_last;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_character = r_ochar;
    assign o_last      = r_olast;

    assign o_status.digit_final = w_step_end &&
        ((n_work == '0) ||
         (r_count == irt_pkg::DIG_CNT_W'(irt_pkg::MAX_DIGITS - 1)));
    assign o_status.emit_final = w_last;
    assign o_status.out_free   = !r_ovalid || i_out_ready;

    // The digit count never runs past the store.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= irt_pkg::DIG_CNT_W'(irt_pkg::MAX_DIGITS))
        else $error("digit count out of range");

    // Every stored digit is below the radix.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.divide && w_step_end) |-> (n_rem < i_radix))
        else $error("remainder not below radix");

    // A sign character is never the final character of a number.
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_sign_pend) |=> (r_ovalid && !r_olast))
        else $error("sign emitted as final character");

endmodule

FILE: rtl/core/integer_to_radix_text_unit.sv
// Channel    Dir  Payload               Transaction
// i_num      in   number[31:0] signed   one number to convert
// o_chr      out  character[7:0], last  one text character, last ends a number
// APB        in   radix, symbol words   register write or read, no wait states
//
// A number is loaded, divided digit by digit, then emitted one character per cycle
// while the output is free (sign plus digits). The divider retires 8 quotient
// bits a cycle, so one digit costs four passes over the 32-bit magnitude.
// Reset is synchronous, active low; no clearing pass is needed.
// The character register holds under stall, and the next number is taken
// while the final character of the previous one still waits.
//
// Top level of the integer-to-radix-text unit; depends on irt_pkg, the
// interfaces in irt_ifs, irt_cfg_regs, irt_ctrl and irt_datapath.

module integer_to_radix_text_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    irt_num_if.sink                     i_num,
    irt_chr_if.source                   o_chr,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [irt_pkg::PADDR_W-1:0] paddr,
    input  logic [irt_pkg::PDATA_W-1:0] pwdata,
    output logic [irt_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    logic [irt_pkg::RADIX_W-1:0] w_radix;
    logic [irt_pkg::SYMS_W-1:0]  w_sym_lo;
    logic [irt_pkg::SYMS_W-1:0]  w_sym_hi;
    logic                        w_alpha_ok;
    logic                        w_in_ready;
    irt_pkg::t_dp_cmd            w_cmd;
    irt_pkg::t_dp_status         w_status;
    logic                        w_out_valid;
    logic [irt_pkg::CHAR_W-1:0]  w_character;
    logic                        w_last;

    // Configuration registers.
    irt_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_radix    (w_radix),
        .o_sym_lo   (w_sym_lo),
        .o_sym_hi   (w_sym_hi),
        .o_alpha_ok (w_alpha_ok)
    );

    // Controller.
    irt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_num.valid),
        .i_alpha_ok (w_alpha_ok),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    irt_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_number    (i_num.number),
        .i_radix     (w_radix),
        .i_sym_lo    (w_sym_lo),
        .i_sym_hi    (w_sym_hi),
        .i_out_ready (o_chr.ready),
        .o_status    (w_status),
        .o_out_valid (w_out_valid),
        .o_character (w_character),
        .o_last      (w_last)
    );

    assign i_num.ready     = w_in_ready;
    assign o_chr.valid     = w_out_valid;
    assign o_chr.character = w_character;
    assign o_chr.last      = w_last;

endmodule

FILE: tb/sv/integer_to_radix_text_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for integer_to_radix_text_unit: converts numbers through the
// handshake channels and checks every emitted character against its own text predictor.
// Depends on irt_pkg, the channel interfaces in irt_ifs and the unit's top level.

module integer_to_radix_text_unit_test;

    localparam int unsigned SETTLE_CYCLES = 200;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;

    // Register index that decodes to no register.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum int {
        FLAW_NONE,
        FLAW_PLUS,
        FLAW_MINUS,
        FLAW_REPEAT
    } t_alphabet_flaw;

    typedef struct packed {
        logic [irt_pkg::CHAR_W-1:0] character;
        logic                       last;
    } t_text_char;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [irt_pkg::PADDR_W-1:0]  paddr;
    logic [irt_pkg::PDATA_W-1:0]  pwdata;
    logic [irt_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    irt_num_if num_if ();
    irt_chr_if chr_if ();

    // Shadow copy of the configuration registers.
    logic [irt_pkg::RADIX_W-1:0] cfg_radix;
    logic [irt_pkg::SYMS_W-1:0]  cfg_sym_lo;
    logic [irt_pkg::SYMS_W-1:0]  cfg_sym_hi;

    t_text_char  pending_chars[$];
    int          failures;
    int unsigned cycle_count;
    bit          idling_on;
    bit          hold_request;

    integer_to_radix_text_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (num_if),
        .o_chr   (chr_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Symbol d of the shadow alphabet.
    function automatic logic [irt_pkg::CHAR_W-1:0] symbol_of(
        input logic [irt_pkg::DIGIT_W-1:0] digit
    );
        logic [2*irt_pkg::SYMS_W-1:0] all_syms;
        all_syms = {cfg_sym_hi, cfg_sym_lo};
        return all_syms[{digit, 3'b000} +: irt_pkg::CHAR_W];
    endfunction

    // True when the radix is in range and the symbols in use are distinct non-signs.
    function automatic bit alphabet_usable();
        logic [irt_pkg::CHAR_W-1:0] sym;
        if ((cfg_radix < 2) || (cfg_radix > irt_pkg::MAX_SYMBOLS)) begin
            return 1'b0;
        end
        for (int i = 0; i < int'(cfg_radix); i++) begin
            sym = symbol_of(irt_pkg::DIGIT_W'(i));
            if ((sym == irt_pkg::PLUS_CHAR) || (sym == irt_pkg::MINUS_CHAR)) begin
                return 1'b0;
            end
            for (int j = 0; j < i; j++) begin
                if (symbol_of(irt_pkg::DIGIT_W'(j)) == sym) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // Queue the characters that one number should produce under the current alphabet.
    function automatic void predict_text(input logic signed [irt_pkg::NUM_W-1:0] value);
        logic [irt_pkg::NUM_W-1:0]   magnitude;
        logic [irt_pkg::DIGIT_W-1:0] digits [irt_pkg::MAX_DIGITS];
        int                          count;
        t_text_char                  ch;
        if (!alphabet_usable()) begin
            return;
        end
        magnitude = value[irt_pkg::NUM_W-1] ? (32'd0 - value) : value;
        count = 0;
        do begin
            digits[count] = irt_pkg::DIGIT_W'(magnitude % cfg_radix);
            magnitude     = magnitude / cfg_radix;
            count++;
        end while ((magnitude != 0) && (count < irt_pkg::MAX_DIGITS));
        if (value[irt_pkg::NUM_W-1]) begin
            ch.character = irt_pkg::MINUS_CHAR;
            ch.last      = 1'b0;
            pending_chars.push_back(ch);
        end
        for (int i = count - 1; i >= 0; i--) begin
            ch.character = symbol_of(digits[i]);
            ch.last      = (i == 0);
            pending_chars.push_back(ch);
        end
    endfunction

    // Mix of full-range, small, extreme and shortened values of either sign.
    function automatic logic signed [irt_pkg::NUM_W-1:0] random_number();
        logic [irt_pkg::NUM_W-1:0] v;
        case ($urandom_range(0, 4))
            0: begin
                v = $urandom_range(0, 40);
            end
            1: begin
                v = 32'd0 - 32'($urandom_range(0, 40));
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
            3: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1) begin
                    v = 32'd0 - v;
                end
            end
            default: begin
                v = $urandom;
            end
        endcase
        return v;
    endfunction

    // Offer one number and wait until the unit takes it; valid stays high afterwards.
    task automatic send_number(input logic signed [irt_pkg::NUM_W-1:0] value);
        int gap;
        gap = 0;
        if (idling_on && ($urandom_range(0, 3) == 0)) begin
            gap = $urandom_range(1, 10);
        end
        if (gap > 0) begin
            num_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        num_if.valid  <= 1'b1;
        num_if.number <= value;
        do @(posedge i_clk); while (!num_if.ready);
        predict_text(value);
    endtask

    // Drop valid, wait for all outstanding characters, then let the unit drain.
    task automatic settle();
        num_if.valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write: setup cycle, then access cycle.
    task automatic write_reg(input logic [1:0]                index,
                             input logic [irt_pkg::SYMS_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            irt_pkg::REG_RADIX:  cfg_radix  = value[irt_pkg::RADIX_W-1:0];
            irt_pkg::REG_SYM_LO: cfg_sym_lo = value;
            irt_pkg::REG_SYM_HI: cfg_sym_hi = value;
            default: ;
        endcase
    endtask

    // Read one register back and compare it with the shadow copy.
    task automatic check_register(input logic [1:0] index);
        logic [irt_pkg::PDATA_W-1:0] expected;
        logic [irt_pkg::PDATA_W-1:0] mask;
        mask = '1;
        case (index)
            irt_pkg::REG_RADIX: begin
                expected = irt_pkg::PDATA_W'(cfg_radix);
                mask     = irt_pkg::PDATA_W'({irt_pkg::RADIX_W{1'b1}});
            end
            irt_pkg::REG_SYM_LO: expected = cfg_sym_lo;
            default:             expected = cfg_sym_hi;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {index, 3'b000};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((prdata & mask) !== expected) begin
            $error("register %0d mismatch: expected 64'h%016h, actual 64'h%016h",
                   index, expected, prdata & mask);
            failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_alphabet(input logic [irt_pkg::RADIX_W-1:0] radix_val,
                                input logic [irt_pkg::SYMS_W-1:0]  sym_lo,
                                input logic [irt_pkg::SYMS_W-1:0]  sym_hi);
        settle();
        write_reg(irt_pkg::REG_RADIX, irt_pkg::SYMS_W'(radix_val));
        write_reg(irt_pkg::REG_SYM_LO, sym_lo);
        write_reg(irt_pkg::REG_SYM_HI, sym_hi);
    endtask

    // Sixteen distinct random non-sign symbols, optionally spoiled inside the radix.
    task automatic load_random_alphabet(input logic [irt_pkg::RADIX_W-1:0] radix_val,
                                        input t_alphabet_flaw              flaw);
        logic [irt_pkg::CHAR_W-1:0]   syms [irt_pkg::MAX_SYMBOLS];
        bit                           taken [256];
        logic [2*irt_pkg::SYMS_W-1:0] packed_syms;
        int                           pos;
        for (int i = 0; i < 256; i++) begin
            taken[i] = 1'b0;
        end
        for (int i = 0; i < irt_pkg::MAX_SYMBOLS; i++) begin
            do begin
                syms[i] = irt_pkg::CHAR_W'($urandom_range(0, 255));
            end while (taken[syms[i]] || (syms[i] == irt_pkg::PLUS_CHAR) ||
                       (syms[i] == irt_pkg::MINUS_CHAR));
            taken[syms[i]] = 1'b1;
        end
        pos = $urandom_range(1, int'(radix_val) - 1);
        case (flaw)
            FLAW_PLUS:   syms[pos] = irt_pkg::PLUS_CHAR;
            FLAW_MINUS:  syms[pos] = irt_pkg::MINUS_CHAR;
            FLAW_REPEAT: syms[pos] = syms[$urandom_range(0, pos - 1)];
            default: ;
        endcase
        for (int i = 0; i < irt_pkg::MAX_SYMBOLS; i++) begin
            packed_syms[8*i +: 8] = syms[i];
        end
        set_alphabet(radix_val, packed_syms[irt_pkg::SYMS_W-1:0],
                     packed_syms[2*irt_pkg::SYMS_W-1:irt_pkg::SYMS_W]);
    endtask

    // Character sink: random stalls, and a long hold-off on request.
    initial begin : character_sink
        int stall;
        chr_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                chr_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idling_on && ($urandom_range(0, 7) == 0)) begin
                stall = $urandom_range(1, 10);
                chr_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            chr_if.ready <= 1'b1;
        end
    end

    // Compare each character transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && chr_if.valid && chr_if.ready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected character 8'h%02h (last %0b)", chr_if.character,
                       chr_if.last);
                failures++;
            end else begin
                want = pending_chars.pop_front();
                if (chr_if.character !== want.character) begin
                    $error("character mismatch: expected 8'h%02h, actual 8'h%02h",
                           want.character, chr_if.character);
                    failures++;
                end
                if (chr_if.last !== want.last) begin
                    $error("last mismatch: expected %0b, actual %0b", want.last,
                           chr_if.last);
                    failures++;
                end
            end
        end
    end

    // Reset values read back; the reset alphabet repeats a zero byte, so nothing comes out.
    task automatic test_reset_state();
        check_register(irt_pkg::REG_RADIX);
        check_register(irt_pkg::REG_SYM_LO);
        check_register(irt_pkg::REG_SYM_HI);
        send_number(0);
        send_number(123);
    endtask

    task automatic test_decimal_extremes();
        set_alphabet(5'd10, irt_pkg::SYM_LO_RESET, 64'h3938);
        send_number(0);
        send_number(-1);
        send_number(32'sh7FFF_FFFF);
        send_number(32'sh8000_0000);
        send_number(9);
        send_number(-10);
        send_number(1_000_000_000);
    endtask

    // Radix two gives the longest texts, up to a sign and 32 digits.
    task automatic test_binary_longest();
        set_alphabet(5'd2, 64'h3130, 64'h0);
        send_number(32'sh8000_0000);
        send_number(32'sh7FFF_FFFF);
        send_number(1);
    endtask

    task automatic test_hex_full_alphabet();
        set_alphabet(5'd16, irt_pkg::SYM_LO_RESET, 64'h4645_4443_4241_3938);
        check_register(irt_pkg::REG_RADIX);
        check_register(irt_pkg::REG_SYM_LO);
        check_register(irt_pkg::REG_SYM_HI);
        send_number(32'shDEAD_BEEF);
        send_number(32'sh7FFF_FFFF);
        send_number(32'sh8000_0000);
    endtask

    // Each broken alphabet must suppress all output.
    task automatic test_invalid_alphabets();
        set_alphabet(5'd0, irt_pkg::SYM_LO_RESET, 64'h4645_4443_4241_3938);
        send_number(77);
        set_alphabet(5'd1, irt_pkg::SYM_LO_RESET, 64'h4645_4443_4241_3938);
        send_number(-77);
        set_alphabet(5'd17, irt_pkg::SYM_LO_RESET, 64'h4645_4443_4241_3938);
        send_number(12345);
        set_alphabet(5'd31, irt_pkg::SYM_LO_RESET, 64'h4645_4443_4241_3938);
        send_number(-12345);
        set_alphabet(5'd10, 64'h3736_3534_2B32_3130, 64'h3938);
        send_number(55);
        set_alphabet(5'd16, irt_pkg::SYM_LO_RESET, 64'h4645_4443_4241_2D38);
        send_number(55);
        set_alphabet(5'd16, irt_pkg::SYM_LO_RESET, 64'h3045_4443_4241_3938);
        send_number(55);
    endtask

    // A zero byte is an ordinary symbol, and signs or repeats past the radix are ignored.
    task automatic test_odd_symbols();
        set_alphabet(5'd3, 64'h2B2D_2D2B_0078_FF00, 64'h0);
        send_number(0);
        send_number(-5);
    endtask

    // A write to the unused register index changes nothing.
    task automatic test_unused_register();
        settle();
        write_reg(REG_UNUSED, '1);
        send_number(-8);
    endtask

    // The sink holds off while numbers keep coming, so the unit fills and stalls its input.
    task automatic test_output_backpressure();
        set_alphabet(5'd10, irt_pkg::SYM_LO_RESET, 64'h3938);
        hold_request = 1'b1;
        for (int i = 0; i < 8; i++) begin
            send_number(random_number());
        end
    endtask

    task automatic test_random_alphabets();
        logic [irt_pkg::RADIX_W-1:0] radix_val;
        t_alphabet_flaw              flaw;
        for (int phase = 0; phase < 8; phase++) begin
            radix_val = (phase == 0) ? 5'd2 : (phase == 1) ? 5'd16 :
                        irt_pkg::RADIX_W'($urandom_range(2, 16));
            flaw = FLAW_NONE;
            if (phase == 5) begin
                flaw = t_alphabet_flaw'($urandom_range(1, 3));
            end
            load_random_alphabet(radix_val, flaw);
            for (int i = 0; i < 30; i++) begin
                send_number(random_number());
            end
        end
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_streaming();
        settle();
        idling_on = 1'b0;
        load_random_alphabet(irt_pkg::RADIX_W'($urandom_range(2, 16)), FLAW_NONE);
        for (int i = 0; i < 40; i++) begin
            send_number(random_number());
        end
    endtask

    initial begin
        failures      = 0;
        cycle_count   = 0;
        idling_on     = 1'b1;
        hold_request  = 1'b0;
        cfg_radix     = irt_pkg::RADIX_RESET;
        cfg_sym_lo    = irt_pkg::SYM_LO_RESET;
        cfg_sym_hi    = irt_pkg::SYM_HI_RESET;
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        num_if.valid  <= 1'b0;
        num_if.number <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_decimal_extremes();
        test_binary_longest();
        test_hex_full_alphabet();
        test_invalid_alphabets();
        test_odd_symbols();
        test_unused_register();
        test_output_backpressure();
        test_random_alphabets();
        test_streaming();
        settle();

        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
